// ===== rtl/cs_pkg.sv =====
// Shared constants and types for the column standardizer.
package cs_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int CNT_W       = $clog2(MAX_ROWS + 1);
  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 23;
  localparam int DEV_W       = SAMPLE_W + 1;
  localparam int SQ_W        = 32;
  localparam int SSD_W       = 39;
  localparam int DIV_NUM_W   = 39;
  localparam int DIV_DEN_W   = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);
  localparam int MAG_W       = 25;
  localparam int SQRT_RAD_W  = 40;
  localparam int SQRT_STEPS  = SQRT_RAD_W / 2;
  localparam int SQRT_ROOT_W = SQRT_STEPS;
  localparam int SQRT_REM_W  = SQRT_ROOT_W + 2;
  localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One queued input beat with its front-end classification.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                keep;
  } q_entry_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/cs_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module cs_divider
  import cs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] quot;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_dif;
  logic                 ge;

  always_comb begin
    rem_sh  = {rem, quot[DIV_NUM_W-1]};
    ge      = rem_sh >= {1'b0, den};
    rem_dif = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.num;
      rem  <= '0;
      den  <= req.den;
    end else if (busy) begin
      quot <= {quot[DIV_NUM_W-2:0], ge};
      rem  <= ge ? rem_dif[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// ===== rtl/cs_queue.sv =====
// Short FIFO of classified beats between front end and back end.
module cs_queue
  import cs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output logic     full,
  output logic     head_valid,
  output q_entry_t head
);

  q_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      priority if (push && !pop) count <= count + 1'b1;
      else if (pop && !push)     count <= count - 1'b1;
      else                       count <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

// ===== rtl/cs_front.sv =====
// Input side: takes sample beats and marks which ones fit in the column buffer.
module cs_front
  import cs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                last_sample,
  input  logic                full,
  output logic                push,
  output q_entry_t            push_data
);

  logic [CNT_W-1:0] count;
  logic             keep;

  assign in_stall         = full;
  assign push             = in_valid && !full;
  assign keep             = count < CNT_W'(MAX_ROWS);
  assign push_data.sample = sample;
  assign push_data.last   = last_sample;
  assign push_data.keep   = keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      // restart on column close, drop overflow beats from the count
      priority if (last_sample) count <= '0;
      else if (keep)            count <= count + 1'b1;
      else                      count <= count;
    end
  end

endmodule

// ===== rtl/cs_back.sv =====
// Back end: column buffer, statistics sequencer, root unit and result register.
module cs_back
  import cs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_enable,
  input  logic                cfg_write_data,
  input  logic                head_valid,
  input  q_entry_t            head,
  output logic                pop,
  output div_req_t            div_req,
  input  div_rsp_t            div_rsp,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] value,
  output logic [ROW_W-1:0]    position,
  output logic [SAMPLE_W-1:0] column_mean,
  output logic [SAMPLE_W-1:0] column_stddev,
  output logic                last_result
);

  typedef enum logic [14:0] {
    S_LOAD         = 15'h0001,
    S_MEAN_GO      = 15'h0002,
    S_MEAN_WAIT    = 15'h0004,
    S_DEV_RD       = 15'h0008,
    S_DEV_MUL      = 15'h0010,
    S_DEV_ACC      = 15'h0020,
    S_VAR_GO       = 15'h0040,
    S_VAR_WAIT     = 15'h0080,
    S_SQRT         = 15'h0100,
    S_SQRT_RND     = 15'h0200,
    S_OUT_RD       = 15'h0400,
    S_OUT_DEV      = 15'h0800,
    S_OUT_DIV_GO   = 15'h1000,
    S_OUT_DIV_WAIT = 15'h2000,
    S_OUT_EMIT     = 15'h4000
  } state_t;

  state_t state;
  logic   scale_enable;

  logic [SAMPLE_W-1:0]    column_store [MAX_ROWS];
  logic [CNT_W-1:0]       row_count;
  logic signed [SUM_W-1:0] running_sum;

  logic [CNT_W-1:0]       idx;
  logic [SAMPLE_W-1:0]    rdata;
  logic [SAMPLE_W-1:0]    mean;
  logic [DEV_W-1:0]       dev;
  logic [SQ_W-1:0]        prod;
  logic [SSD_W-1:0]       ssd;
  logic [SQRT_RAD_W-1:0]  rad;
  logic [SQRT_ROOT_W-1:0] root;
  logic [SQRT_REM_W-1:0]  rem;
  logic [SQRT_CNT_W-1:0]  step;
  logic [SAMPLE_W-1:0]    stddev;
  logic [MAG_W-1:0]       res_mag;

  logic [CNT_W-1:0]          n_less;
  logic                      last_row;
  logic                      out_free;
  logic [SUM_W-1:0]          sum_mag;
  logic [DEV_W-1:0]          dev_c;
  logic [SAMPLE_W-1:0]       dev_mag;
  logic signed [2*DEV_W-1:0] sq_full;
  logic [SQRT_REM_W+1:0]     rem_sh;
  logic [SQRT_REM_W+1:0]     trial;
  logic                      take;
  logic [SQRT_ROOT_W:0]      root_rnd;
  logic [SAMPLE_W-1:0]       val_c;

  assign pop      = (state == S_LOAD) && head_valid;
  assign n_less   = row_count - 1'b1;
  assign last_row = idx == n_less;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    sum_mag = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : running_sum;
    dev_c   = {rdata[SAMPLE_W-1], rdata} - {mean[SAMPLE_W-1], mean};
    dev_mag = dev[DEV_W-1] ? SAMPLE_W'(-dev) : dev[SAMPLE_W-1:0];
    // square the deviation of the row that the buffer read just returned
    sq_full = $signed(dev_c) * $signed(dev_c);
    rem_sh  = {rem, rad[SQRT_RAD_W-1 -: 2]};
    trial   = {2'b00, root, 2'b01};
    take    = rem_sh >= trial;
    root_rnd = {1'b0, root} + ((rem > SQRT_REM_W'(root)) ? 1'b1 : 1'b0);
    // saturate the signed result to the 16-bit range
    if (!dev[DEV_W-1]) begin
      val_c = (res_mag > MAG_W'(32767)) ? 16'h7FFF : res_mag[SAMPLE_W-1:0];
    end else begin
      val_c = (res_mag > MAG_W'(32768)) ? 16'h8000 : SAMPLE_W'(-res_mag[SAMPLE_W-1:0]);
    end
  end

  always_comb begin
    div_req.start = (state == S_MEAN_GO) || (state == S_VAR_GO) || (state == S_OUT_DIV_GO);
    unique case (state)
      S_MEAN_GO: begin
        div_req.num = DIV_NUM_W'(sum_mag) + DIV_NUM_W'(row_count >> 1);
        div_req.den = DIV_DEN_W'(row_count);
      end
      S_VAR_GO: begin
        div_req.num = ssd + DIV_NUM_W'(n_less >> 1);
        div_req.den = DIV_DEN_W'(n_less);
      end
      default: begin
        div_req.num = (DIV_NUM_W'(dev_mag) << 8) + DIV_NUM_W'(stddev >> 1);
        div_req.den = stddev;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      scale_enable <= 1'b1;
      row_count    <= '0;
      running_sum  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write_enable) scale_enable <= cfg_write_data;
      if (out_valid && !out_stall && state != S_OUT_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (pop) begin
            if (head.keep) begin
              row_count   <= row_count + 1'b1;
              running_sum <= running_sum +
                             SUM_W'($signed(head.sample));
            end
            if (head.last) state <= S_MEAN_GO;
          end
        end
        S_MEAN_GO:   state <= S_MEAN_WAIT;
        S_MEAN_WAIT: begin
          if (div_rsp.done) state <= (row_count > CNT_W'(1)) ? S_DEV_RD : S_OUT_RD;
        end
        S_DEV_RD:    state <= S_DEV_MUL;
        S_DEV_MUL:   state <= S_DEV_ACC;
        S_DEV_ACC:   state <= last_row ? S_VAR_GO : S_DEV_RD;
        S_VAR_GO:    state <= S_VAR_WAIT;
        S_VAR_WAIT:  if (div_rsp.done) state <= S_SQRT;
        S_SQRT:      if (step == SQRT_CNT_W'(SQRT_STEPS - 1)) state <= S_SQRT_RND;
        S_SQRT_RND:  state <= S_OUT_RD;
        S_OUT_RD:    state <= S_OUT_DEV;
        S_OUT_DEV: begin
          state <= (scale_enable && stddev != '0) ? S_OUT_DIV_GO : S_OUT_EMIT;
        end
        S_OUT_DIV_GO:   state <= S_OUT_DIV_WAIT;
        S_OUT_DIV_WAIT: if (div_rsp.done) state <= S_OUT_EMIT;
        S_OUT_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (last_row) begin
              state       <= S_LOAD;
              row_count   <= '0;
              running_sum <= '0;
            end else begin
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_MEAN_WAIT: begin
        if (div_rsp.done) begin
          mean   <= running_sum[SUM_W-1] ? SAMPLE_W'(-div_rsp.quot[SAMPLE_W-1:0])
                                         : div_rsp.quot[SAMPLE_W-1:0];
          idx    <= '0;
          ssd    <= '0;
          stddev <= '0;
        end
      end
      S_DEV_MUL: prod <= sq_full[SQ_W-1:0];
      S_DEV_ACC: begin
        ssd <= ssd + SSD_W'(prod);
        idx <= last_row ? '0 : idx + 1'b1;
      end
      S_VAR_WAIT: begin
        if (div_rsp.done) begin
          rad  <= SQRT_RAD_W'(div_rsp.quot);
          root <= '0;
          rem  <= '0;
          step <= '0;
        end
      end
      S_SQRT: begin
        rad  <= rad << 2;
        root <= {root[SQRT_ROOT_W-2:0], take};
        rem  <= take ? SQRT_REM_W'(rem_sh - trial) : SQRT_REM_W'(rem_sh);
        step <= step + 1'b1;
      end
      S_SQRT_RND: begin
        stddev <= (root_rnd > (SQRT_ROOT_W+1)'(16'hFFFF)) ? 16'hFFFF
                                                         : root_rnd[SAMPLE_W-1:0];
      end
      S_OUT_DEV: begin
        dev     <= dev_c;
        res_mag <= MAG_W'(dev_c[DEV_W-1] ? SAMPLE_W'(-dev_c) : dev_c[SAMPLE_W-1:0]);
      end
      S_OUT_DIV_WAIT: begin
        if (div_rsp.done) res_mag <= div_rsp.quot[MAG_W-1:0];
      end
      S_OUT_EMIT: begin
        if (out_free) begin
          value         <= val_c;
          position      <= idx[ROW_W-1:0];
          column_mean   <= mean;
          column_stddev <= stddev;
          last_result   <= last_row;
          idx           <= idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (state == S_DEV_RD || state == S_OUT_RD) dev <= dev_c;
  end

  // column buffer: write on load, registered read at idx
  always_ff @(posedge clk) begin
    if (pop && head.keep) column_store[row_count[ROW_W-1:0]] <= head.sample;
    rdata <= column_store[idx[ROW_W-1:0]];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    row_count <= CNT_W'(MAX_ROWS))
    else $error("row count past buffer depth");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT_EMIT) |-> (idx < row_count))
    else $error("emit index past column length");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_MEAN_WAIT || state == S_VAR_WAIT ||
                      state == S_OUT_DIV_WAIT))
    else $error("divider result with no waiting consumer");

endmodule

// ===== rtl/column_standardize.sv =====
// Column z-score unit: top level joining front end, queue, back end and divider.
//
// Samples stream in one beat per cycle, while in_stall is low, through a four-entry
// queue; up to 64 rows are buffered and later rows are dropped. The beat marked last
// closes the column. The back end then computes the mean with the shared bit-serial
// divider and, for more than one row, walks the buffer (read, multiply, accumulate)
// for the squared deviations, divides by n-1 and takes a 20-step square root. It
// emits one result per row, passing it through the divider only when scaling with a
// nonzero deviation. Input beats of the next column are queued while a column is
// being emitted, until the queue is full.
module column_standardize
  import cs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_enable,
  input  logic                cfg_write_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                last_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] value,
  output logic [ROW_W-1:0]    position,
  output logic [SAMPLE_W-1:0] column_mean,
  output logic [SAMPLE_W-1:0] column_stddev,
  output logic                last_result
);

  logic     push;
  q_entry_t push_data;
  logic     full;
  logic     pop;
  logic     head_valid;
  q_entry_t head;
  div_req_t div_req;
  div_rsp_t div_rsp;

  cs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .last_sample (last_sample),
    .full        (full),
    .push        (push),
    .push_data   (push_data)
  );

  cs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  cs_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  cs_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .div_req          (div_req),
    .div_rsp          (div_rsp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .value            (value),
    .position         (position),
    .column_mean      (column_mean),
    .column_stddev    (column_stddev),
    .last_result      (last_result)
  );

endmodule

// ===== bench/column_checker.sv =====
// Watches the column standardizer channels, predicts each result beat and compares.
module column_checker
  import cs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_enable,
  input  logic                cfg_write_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                last_sample,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [SAMPLE_W-1:0] value,
  input  logic [ROW_W-1:0]    position,
  input  logic [SAMPLE_W-1:0] column_mean,
  input  logic [SAMPLE_W-1:0] column_stddev,
  input  logic                last_result,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [ROW_W-1:0]    position;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] stddev;
    logic                last;
  } row_result_t;

  row_result_t         expected_rows[$];
  logic [SAMPLE_W-1:0] rows[MAX_ROWS];
  int                  row_total;
  int                  col_sum;
  logic                scale_on;

  assign pending = expected_rows.size();

  // Round to nearest, ties away from zero; den is positive.
  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint root_nearest(longint unsigned v);
    longint unsigned r, b, x;
    r = 0;
    b = 64'd1 << 62;
    x = v;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (v - r * r > r) r++;
    return r;
  endfunction

  task automatic close_column();
    longint      mean, d, v, sd;
    longint      ssd;
    row_result_t res;
    mean = round_div(col_sum, row_total);
    ssd = 0;
    sd = 0;
    if (row_total > 1) begin
      for (int i = 0; i < row_total; i++) begin
        d = longint'($signed(rows[i])) - mean;
        ssd += d * d;
      end
      sd = root_nearest((ssd + (row_total - 1) / 2) / (row_total - 1));
      if (sd > 65535) sd = 65535;
    end
    for (int i = 0; i < row_total; i++) begin
      d = longint'($signed(rows[i])) - mean;
      v = (scale_on && sd != 0) ? round_div(d * 256, sd) : d;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      res.value    = v[SAMPLE_W-1:0];
      res.position = i[ROW_W-1:0];
      res.mean     = mean[SAMPLE_W-1:0];
      res.stddev   = sd[SAMPLE_W-1:0];
      res.last     = (i == row_total - 1);
      expected_rows.push_back(res);
    end
    row_total = 0;
    col_sum = 0;
  endtask

  always @(posedge clk) begin
    row_result_t want;
    if (rst) begin
      row_total = 0;
      col_sum = 0;
      scale_on = 1'b1;
      fail_count = 0;
      expected_rows.delete();
    end else begin
      if (cfg_write_enable) scale_on = cfg_write_data;
      if (in_valid && !in_stall) begin
        // drop rows past the buffer, but still let last close the column
        if (row_total < MAX_ROWS) begin
          rows[row_total] = sample;
          col_sum += int'($signed(sample));
          row_total++;
        end
        if (last_sample) close_column();
      end
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          $error("result beat with nothing expected: value %0d position %0d",
                 $signed(value), position);
          fail_count++;
        end else begin
          want = expected_rows.pop_front();
          if (value !== want.value) begin
            $error("value: expected %0d, got %0d", $signed(want.value), $signed(value));
            fail_count++;
          end
          if (position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, position);
            fail_count++;
          end
          if (column_mean !== want.mean) begin
            $error("column_mean: expected %0d, got %0d",
                   $signed(want.mean), $signed(column_mean));
            fail_count++;
          end
          if (column_stddev !== want.stddev) begin
            $error("column_stddev: expected %0d, got %0d", want.stddev, column_stddev);
            fail_count++;
          end
          if (last_result !== want.last) begin
            $error("last_result: expected %0d, got %0d", want.last, last_result);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Stimulus, idling and verdict for the column standardizer bench.
module tb_top;
  import cs_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  logic                clk;
  logic                rst;
  logic                cfg_write_enable;
  logic                cfg_write_data;
  logic                in_valid;
  logic                in_stall;
  logic [SAMPLE_W-1:0] sample;
  logic                last_sample;
  logic                out_valid;
  logic                out_stall;
  logic [SAMPLE_W-1:0] value;
  logic [ROW_W-1:0]    position;
  logic [SAMPLE_W-1:0] column_mean;
  logic [SAMPLE_W-1:0] column_stddev;
  logic                last_result;
  int                  fail_count;
  int                  pending;
  logic                in_beat;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  quiet_cycles;
  int                  items_sent;
  int                  columns_sent;

  column_standardize u_top (
    .clk(clk), .rst(rst),
    .cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample(sample), .last_sample(last_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .value(value), .position(position), .column_mean(column_mean),
    .column_stddev(column_stddev), .last_result(last_result)
  );

  column_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample(sample), .last_sample(last_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .value(value), .position(position), .column_mean(column_mean),
    .column_stddev(column_stddev), .last_result(last_result),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) in_beat <= in_valid && !in_stall;

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // end the run if neither channel moves a beat for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays high after the beat is taken; the next beat or a caller drops it
  task automatic send_beat(logic [SAMPLE_W-1:0] s, logic lst);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    sample      <= s;
    last_sample <= lst;
    do @(negedge clk); while (!in_beat);
    items_sent++;
    if (lst) columns_sent++;
  endtask

  // hold until the block has drained, then write the mode bit
  task automatic set_scale(logic on);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= on;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  task automatic directed_columns();
    send_beat(16'h1234, 1'b1);
    send_beat(16'h7FFF, 1'b0);
    send_beat(16'h8000, 1'b1);
    repeat (2) send_beat(16'h0180, 1'b0);
    send_beat(16'h0180, 1'b1);
    repeat (2) send_beat(16'h8000, 1'b0);
    send_beat(16'h8000, 1'b0);
    send_beat(16'h7FFF, 1'b1);
    send_beat(16'h0001, 1'b0);
    send_beat(16'h0000, 1'b1);
  endtask

  task automatic random_columns(int target);
    int                  len, pick, kind;
    logic [SAMPLE_W-1:0] base, s;
    int                  stop_at;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 4) len = $urandom_range(68, 63);
      else if (pick < 14) len = $urandom_range(40, 11);
      else len = $urandom_range(10, 1);
      kind = $urandom_range(3);
      base = SAMPLE_W'($urandom);
      for (int i = 0; i < len; i++) begin
        case (kind)
          0: s = SAMPLE_W'($urandom);
          1: s = base + SAMPLE_W'($urandom_range(512)) - SAMPLE_W'(256);
          2: s = base;
          default: s = $urandom_range(1) ? 16'h7FFF - SAMPLE_W'($urandom_range(15))
                                         : 16'h8000 + SAMPLE_W'($urandom_range(15));
        endcase
        send_beat(s, i == len - 1);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_write_data = 1'b0;
    in_valid = 1'b0;
    sample = '0;
    last_sample = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items_sent = 0;
    columns_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_columns();
    set_scale(1'b0);
    directed_columns();

    send_idle_pct = 34;
    recv_idle_pct = 54;
    random_columns(90);
    set_scale(1'b1);
    send_idle_pct = 54;
    recv_idle_pct = 34;
    random_columns(90);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_columns(60);
    set_scale(1'b0);
    random_columns(40);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("tb_top: sent %0d samples in %0d columns, centering and scaling modes,",
             items_sent, columns_sent);
    $display("tb_top: with idling on input, output, both swapped, and none");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
